@@ sv/sdwrd_pkg.sv @@
// sdwrd_pkg: shared types and constants of the sdio wlan register device
// no dependencies

package sdwrd_pkg;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   localparam logic [1:0] REQ_CMD = 2'd0;
   localparam logic [1:0] REQ_RD  = 2'd1;
   localparam logic [1:0] REQ_WR  = 2'd2;
   localparam logic [1:0] REQ_IRQ = 2'd3;

   localparam logic [5:0] CMD_IO_OCR   = 6'd5;
   localparam logic [5:0] CMD_SELECT   = 6'd7;
   localparam logic [5:0] CMD_IO_RW    = 6'd52;
   localparam logic [5:0] CMD_IO_RW_EX = 6'd53;

   localparam logic [31:0] RESP_OCR    = 32'hA0FE_0000;
   localparam logic [31:0] RESP_SELECT = 32'h0000_1E00;
   localparam logic [31:0] RESP_IO     = 32'h0000_1000;

   localparam logic [31:0] CORE_BASE    = 32'h1810_0000;
   localparam logic [11:0] CORE_IO_OFF  = 12'h408;
   localparam logic [11:0] CORE_RST_OFF = 12'h800;
   localparam logic [31:0] REG_IRQ_STATUS = 32'h1800_2020;
   localparam logic [31:0] REG_IRQ_ENABLE = 32'h1800_2024;

   localparam logic [31:0] ID_ADDR0 = 32'h1800_0000;
   localparam logic [31:0] ID_ADDR1 = 32'h1800_0004;
   localparam logic [31:0] ID_ADDR2 = 32'h1800_00FC;
   localparam logic [31:0] ID_ADDR3 = 32'h1800_0604;
   localparam logic [31:0] ID_ADDR4 = 32'h1800_4000;
   localparam logic [31:0] ID_VAL0  = 32'h1691_4319;
   localparam logic [31:0] ID_VAL1  = 32'h1048_0009;
   localparam logic [31:0] ID_VAL2  = 32'h1810_9000;
   localparam logic [31:0] ID_VAL3  = 32'h19CC_3607;
   localparam logic [31:0] ID_VAL4  = 32'h0025_8033;

   localparam logic [31:0] F0_ENABLE  = 32'h0_0002;
   localparam logic [31:0] F0_READY   = 32'h0_0003;
   localparam logic [31:0] F0_CAP     = 32'h0_000A;
   localparam logic [31:0] F0_F1_109  = 32'h0_0109;
   localparam logic [31:0] F0_F1_10A  = 32'h0_010A;
   localparam logic [31:0] F0_F1_BS_L = 32'h0_0110;
   localparam logic [31:0] F0_F1_BS_H = 32'h0_0111;
   localparam logic [31:0] F0_F2_209  = 32'h0_0209;
   localparam logic [31:0] F0_F2_20A  = 32'h0_020A;
   localparam logic [31:0] F0_F2_BS_L = 32'h0_0210;
   localparam logic [31:0] F0_F2_BS_H = 32'h0_0211;
   localparam logic [31:0] F1_WIN_LO  = 32'h1_000A;
   localparam logic [31:0] F1_WIN_MID = 32'h1_000B;
   localparam logic [31:0] F1_WIN_HI  = 32'h1_000C;
   localparam logic [31:0] F1_CLK     = 32'h1_000E;
   localparam logic [31:0] WIN_START  = 32'h0_8000;
   localparam logic [31:0] WIN_END    = 32'h1_0000;

endpackage

@@ sv/sdio_wlan_register_device_unit.sv @@
// sdio_wlan_register_device_unit: card-side sdio register block with backplane ram
// depends on sdwrd_pkg
//
// channel  | ports                                   | handshake
// request  | req_type req_cmd_index req_cmd_arg ...  | start & !busy
// result   | rsp_resp_valid rsp_response ...         | rsp_valid, one cycle, no stall
//
// a request is taken with a ram read while idle, then modified and written back
// in the exec state; its result shows on the cycle after, when the next request
// may already be accepted. after reset a clearing pass zeroes all RAM_WORDS ram
// words, one word a cycle, with busy high; the result side has no stall

module sdio_wlan_register_device_unit #(
   parameter int RAM_WORDS = 73728,
   parameter int NUM_CORES = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [5:0]  req_cmd_index,
   input  logic [31:0] req_cmd_arg,
   input  logic [7:0]  req_data_byte,
   input  logic [4:0]  req_irq_line,
   output logic        rsp_valid,
   output logic        rsp_resp_valid,
   output logic [31:0] rsp_response,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_card_irq
);

   localparam int RAM_AW = $clog2(RAM_WORDS);
   localparam int CW = $clog2(NUM_CORES);
   localparam logic [31:0] RAM_BYTES = 32'(RAM_WORDS * 4);
   localparam logic [31:0] CORE_END = sdwrd_pkg::CORE_BASE + 32'(NUM_CORES * 4096);
   localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_WORDS - 1);

   sdwrd_pkg::state_type state_ff, state_in;
   logic [RAM_AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic [1:0]  type_ff;
   logic [5:0]  idx_ff;
   logic [31:0] arg_ff;
   logic [7:0]  db_ff;
   logic [4:0]  line_ff;

   logic [7:0]  func_enable_ff, func_enable_in, func_ready_ff, func_ready_in;
   logic [15:0] f1_bs_ff, f1_bs_in, f2_bs_ff, f2_bs_in;
   logic [7:0]  clock_ctrl_ff, clock_ctrl_in;
   logic [31:0] window_base_ff, window_base_in, byte_latch_ff, byte_latch_in;
   logic [31:0] core_io_ff [NUM_CORES];
   logic [31:0] core_io_in [NUM_CORES];
   logic [31:0] core_rst_ff [NUM_CORES];
   logic [31:0] core_rst_in [NUM_CORES];
   logic [31:0] irq_status_ff, irq_status_in, irq_enable_ff, irq_enable_in;
   logic [2:0]  xfer_func_ff, xfer_func_in;
   logic [31:0] xfer_addr_ff, xfer_addr_in;
   logic        xfer_incr_ff, xfer_incr_in;
   logic [25:0] xfer_left_ff, xfer_left_in;

   logic        rv_ff, rv_in, dv_ff, dv_in, irq_ff, irq_in, strobe_ff, strobe_in;
   logic [31:0] resp_ff, resp_in;
   logic [7:0]  dout_ff, dout_in;

   logic [31:0] ram [RAM_WORDS];
   logic [31:0] ram_q_ff;
   logic [RAM_AW-1:0] ram_ra, ram_wa;
   logic        ram_we;
   logic [31:0] ram_wd;

   logic        accept;
   logic [16:0] acc_a;
   logic [31:0] acc_bpa;

   logic [2:0]  fn;
   logic [31:0] a, bpa, bp_rdata, bp_wdata;
   logic [1:0]  lane;
   logic        in_win, in_ram, in_core, do_rd, do_wr;
   logic [CW-1:0] cid;
   logic [11:0] off;
   logic [7:0]  wv, rbyte, clk_c;
   logic [9:0]  blk_n;
   logic [25:0] prod;

   assign accept = start && (state_ff == sdwrd_pkg::ST_IDLE);
   assign busy = (state_ff != sdwrd_pkg::ST_IDLE);

   // ram read address from the incoming command, or from the transfer address for data requests
   assign acc_a = req_cmd_arg[25:9];
   always_comb begin
      if (req_type == sdwrd_pkg::REQ_CMD) begin
         acc_bpa = window_base_ff | {17'b0, acc_a[14:2], 2'b00};
      end else begin
         acc_bpa = window_base_ff | {17'b0, xfer_addr_ff[14:2], 2'b00};
      end
   end
   assign ram_ra = acc_bpa[RAM_AW+1:2];

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram[ram_wa] <= ram_wd;
      end
      ram_q_ff <= ram[ram_ra];
   end

   always_comb begin
      state_in = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         sdwrd_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = sdwrd_pkg::ST_IDLE;
            end
         end
         sdwrd_pkg::ST_IDLE: begin
            if (start) begin
               state_in = sdwrd_pkg::ST_EXEC;
            end
         end
         sdwrd_pkg::ST_EXEC: state_in = sdwrd_pkg::ST_IDLE;
         default: state_in = sdwrd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdwrd_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         idx_ff <= req_cmd_index;
         arg_ff <= req_cmd_arg;
         db_ff <= req_data_byte;
         line_ff <= req_irq_line;
      end
   end

   // effective function and address of the request in execution
   always_comb begin
      if (type_ff == sdwrd_pkg::REQ_CMD) begin
         fn = arg_ff[30:28];
         a = {15'b0, arg_ff[25:9]};
         wv = arg_ff[7:0];
      end else begin
         fn = xfer_func_ff;
         a = xfer_addr_ff;
         wv = db_ff;
      end
   end

   assign lane = a[1:0];
   assign in_win = (a >= sdwrd_pkg::WIN_START) && (a < sdwrd_pkg::WIN_END);
   assign bpa = window_base_ff | {17'b0, a[14:2], 2'b00};
   assign in_ram = (bpa < RAM_BYTES);
   assign in_core = (bpa >= sdwrd_pkg::CORE_BASE) && (bpa < CORE_END);
   assign cid = bpa[12 +: CW];
   assign off = bpa[11:0];
   assign blk_n = (arg_ff[8:0] == 9'd0) ? 10'd512 : {1'b0, arg_ff[8:0]};
   assign prod = {16'b0, blk_n} * {10'b0, (fn == 3'd1) ? f1_bs_ff : f2_bs_ff};

   always_comb begin
      clk_c = {2'b00, wv[5:0]};
      if ((clk_c & 8'h09) != 8'h00) begin
         clk_c = clk_c | 8'h40;
      end
      if ((clk_c & 8'h12) != 8'h00) begin
         clk_c = clk_c | 8'hC0;
      end
   end

   // backplane read
   always_comb begin
      bp_rdata = 32'h0;
      if (in_ram) begin
         bp_rdata = ram_q_ff;
      end else if (in_core && off == sdwrd_pkg::CORE_IO_OFF) begin
         bp_rdata = core_io_ff[cid];
      end else if (in_core && off == sdwrd_pkg::CORE_RST_OFF) begin
         bp_rdata = core_rst_ff[cid];
      end else begin
         unique case (bpa)
            sdwrd_pkg::ID_ADDR0: bp_rdata = sdwrd_pkg::ID_VAL0;
            sdwrd_pkg::ID_ADDR1: bp_rdata = sdwrd_pkg::ID_VAL1;
            sdwrd_pkg::ID_ADDR2: bp_rdata = sdwrd_pkg::ID_VAL2;
            sdwrd_pkg::ID_ADDR3: bp_rdata = sdwrd_pkg::ID_VAL3;
            sdwrd_pkg::ID_ADDR4: bp_rdata = sdwrd_pkg::ID_VAL4;
            sdwrd_pkg::REG_IRQ_STATUS: bp_rdata = irq_status_ff;
            sdwrd_pkg::REG_IRQ_ENABLE: bp_rdata = irq_enable_ff;
            default: bp_rdata = 32'h0;
         endcase
      end
   end

   always_comb begin
      func_enable_in = func_enable_ff;
      func_ready_in = func_ready_ff;
      f1_bs_in = f1_bs_ff;
      f2_bs_in = f2_bs_ff;
      clock_ctrl_in = clock_ctrl_ff;
      window_base_in = window_base_ff;
      byte_latch_in = byte_latch_ff;
      core_io_in = core_io_ff;
      core_rst_in = core_rst_ff;
      irq_status_in = irq_status_ff;
      irq_enable_in = irq_enable_ff;
      xfer_func_in = xfer_func_ff;
      xfer_addr_in = xfer_addr_ff;
      xfer_incr_in = xfer_incr_ff;
      xfer_left_in = xfer_left_ff;
      rv_in = 1'b0;
      resp_in = 32'h0;
      dv_in = 1'b0;
      dout_in = 8'h0;
      do_rd = 1'b0;
      do_wr = 1'b0;
      rbyte = 8'h0;
      bp_wdata = 32'h0;
      ram_we = 1'b0;
      ram_wa = bpa[RAM_AW+1:2];
      ram_wd = 32'h0;
      strobe_in = (state_ff == sdwrd_pkg::ST_EXEC);

      if (state_ff == sdwrd_pkg::ST_CLEAR) begin
         ram_we = 1'b1;
         ram_wa = clr_cnt_ff;
      end

      if (state_ff == sdwrd_pkg::ST_EXEC) begin
         unique case (type_ff)
            sdwrd_pkg::REQ_CMD: begin
               if (idx_ff == sdwrd_pkg::CMD_IO_RW) begin
                  do_wr = arg_ff[31];
                  do_rd = !arg_ff[31] || arg_ff[27];
               end
            end
            sdwrd_pkg::REQ_RD, sdwrd_pkg::REQ_WR: begin
               if (xfer_left_ff != 26'd0) begin
                  do_rd = (type_ff == sdwrd_pkg::REQ_RD);
                  do_wr = (type_ff == sdwrd_pkg::REQ_WR);
                  xfer_addr_in = xfer_addr_ff + {31'b0, xfer_incr_ff};
                  xfer_left_in = xfer_left_ff - 26'd1;
               end
            end
            sdwrd_pkg::REQ_IRQ: irq_status_in = irq_status_ff | (32'd1 << line_ff);
            default: irq_status_in = irq_status_ff;
         endcase

         // byte write
         if (do_wr) begin
            if (fn == 3'd0) begin
               priority if (a == sdwrd_pkg::F0_ENABLE) begin
                  func_enable_in = wv;
                  func_ready_in = wv;
               end else if (a == sdwrd_pkg::F0_F1_BS_L) begin
                  f1_bs_in = {f1_bs_ff[15:8], wv};
               end else if (a == sdwrd_pkg::F0_F1_BS_H) begin
                  f1_bs_in = {wv, f1_bs_ff[7:0]};
               end else if (a == sdwrd_pkg::F0_F2_BS_L) begin
                  f2_bs_in = {f2_bs_ff[15:8], wv};
               end else if (a == sdwrd_pkg::F0_F2_BS_H) begin
                  f2_bs_in = {wv, f2_bs_ff[7:0]};
               end else begin
                  f1_bs_in = f1_bs_ff;
               end
            end else if (fn == 3'd1) begin
               priority if (in_win) begin
                  unique case (lane)
                     2'd0: byte_latch_in = {24'b0, wv};
                     2'd1: byte_latch_in = {byte_latch_ff[31:16], wv, byte_latch_ff[7:0]};
                     2'd2: byte_latch_in = {byte_latch_ff[31:24], wv, byte_latch_ff[15:0]};
                     2'd3: byte_latch_in = {wv, byte_latch_ff[23:0]};
                     default: byte_latch_in = byte_latch_ff;
                  endcase
                  if (lane == 2'd3) begin
                     bp_wdata = byte_latch_in;
                     if (in_ram) begin
                        ram_we = 1'b1;
                        ram_wd = bp_wdata;
                     end else if (in_core && off == sdwrd_pkg::CORE_IO_OFF) begin
                        core_io_in[cid] = bp_wdata;
                     end else if (in_core && off == sdwrd_pkg::CORE_RST_OFF) begin
                        core_rst_in[cid] = bp_wdata;
                     end else if (bpa == sdwrd_pkg::REG_IRQ_STATUS) begin
                        irq_status_in = irq_status_ff & ~bp_wdata;
                     end else if (bpa == sdwrd_pkg::REG_IRQ_ENABLE) begin
                        irq_enable_in = bp_wdata;
                     end
                  end
               end else if (a == sdwrd_pkg::F1_WIN_LO) begin
                  window_base_in = {window_base_ff[31:16], wv[7], 15'b0};
               end else if (a == sdwrd_pkg::F1_WIN_MID) begin
                  window_base_in = {window_base_ff[31:24], wv, window_base_ff[15], 15'b0};
               end else if (a == sdwrd_pkg::F1_WIN_HI) begin
                  window_base_in = {wv, window_base_ff[23:15], 15'b0};
               end else if (a == sdwrd_pkg::F1_CLK) begin
                  clock_ctrl_in = clk_c;
               end else begin
                  clock_ctrl_in = clock_ctrl_ff;
               end
            end
         end

         // byte read, after the write of the same request
         if (do_rd) begin
            if (fn == 3'd0) begin
               unique case (a)
                  sdwrd_pkg::F0_ENABLE:  rbyte = func_enable_in;
                  sdwrd_pkg::F0_READY:   rbyte = func_ready_in;
                  sdwrd_pkg::F0_CAP:     rbyte = 8'h10;
                  sdwrd_pkg::F0_F1_109:  rbyte = 8'h03;
                  sdwrd_pkg::F0_F1_10A:  rbyte = 8'h10;
                  sdwrd_pkg::F0_F1_BS_L: rbyte = f1_bs_in[7:0];
                  sdwrd_pkg::F0_F1_BS_H: rbyte = f1_bs_in[15:8];
                  sdwrd_pkg::F0_F2_209:  rbyte = 8'h03;
                  sdwrd_pkg::F0_F2_20A:  rbyte = 8'h10;
                  sdwrd_pkg::F0_F2_BS_L: rbyte = f2_bs_in[7:0];
                  sdwrd_pkg::F0_F2_BS_H: rbyte = f2_bs_in[15:8];
                  default: rbyte = 8'h0;
               endcase
            end else if (fn == 3'd1) begin
               if (in_win) begin
                  if (lane == 2'd0) begin
                     byte_latch_in = bp_rdata;
                  end
                  rbyte = byte_latch_in[8*lane +: 8];
               end else begin
                  unique case (a)
                     sdwrd_pkg::F1_WIN_LO:  rbyte = {window_base_in[15], 7'b0};
                     sdwrd_pkg::F1_WIN_MID: rbyte = window_base_in[23:16];
                     sdwrd_pkg::F1_WIN_HI:  rbyte = window_base_in[31:24];
                     sdwrd_pkg::F1_CLK:     rbyte = clock_ctrl_in;
                     default: rbyte = 8'h0;
                  endcase
               end
            end
         end

         if (type_ff == sdwrd_pkg::REQ_CMD) begin
            priority if (idx_ff == sdwrd_pkg::CMD_IO_OCR) begin
               rv_in = 1'b1;
               resp_in = sdwrd_pkg::RESP_OCR;
            end else if (idx_ff == sdwrd_pkg::CMD_SELECT) begin
               rv_in = 1'b1;
               resp_in = sdwrd_pkg::RESP_SELECT;
            end else if (idx_ff == sdwrd_pkg::CMD_IO_RW) begin
               rv_in = 1'b1;
               resp_in = sdwrd_pkg::RESP_IO | {24'b0, (do_rd ? rbyte : 8'h0)};
            end else if (idx_ff == sdwrd_pkg::CMD_IO_RW_EX) begin
               xfer_func_in = fn;
               xfer_addr_in = a;
               xfer_incr_in = arg_ff[26];
               if (!arg_ff[27]) begin
                  xfer_left_in = {16'b0, blk_n};
                  rv_in = 1'b1;
               end else if (fn == 3'd1 || fn == 3'd2) begin
                  xfer_left_in = prod;
                  rv_in = 1'b1;
               end
               resp_in = rv_in ? sdwrd_pkg::RESP_IO : 32'h0;
            end else begin
               rv_in = 1'b0;
            end
         end else begin
            dv_in = do_rd;
            dout_in = rbyte;
         end
      end
      irq_in = |(irq_status_in & irq_enable_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         func_enable_ff <= '0;
         func_ready_ff <= '0;
         f1_bs_ff <= '0;
         f2_bs_ff <= '0;
         clock_ctrl_ff <= '0;
         window_base_ff <= '0;
         byte_latch_ff <= '0;
         for (int i = 0; i < NUM_CORES; i++) begin
            core_io_ff[i] <= (i == 0 || i == 2) ? 32'd1 : 32'd0;
            core_rst_ff[i] <= (i == 0 || i == 2) ? 32'd0 : 32'd1;
         end
         irq_status_ff <= '0;
         irq_enable_ff <= '0;
         xfer_func_ff <= '0;
         xfer_addr_ff <= '0;
         xfer_incr_ff <= 1'b0;
         xfer_left_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         func_enable_ff <= func_enable_in;
         func_ready_ff <= func_ready_in;
         f1_bs_ff <= f1_bs_in;
         f2_bs_ff <= f2_bs_in;
         clock_ctrl_ff <= clock_ctrl_in;
         window_base_ff <= window_base_in;
         byte_latch_ff <= byte_latch_in;
         core_io_ff <= core_io_in;
         core_rst_ff <= core_rst_in;
         irq_status_ff <= irq_status_in;
         irq_enable_ff <= irq_enable_in;
         xfer_func_ff <= xfer_func_in;
         xfer_addr_ff <= xfer_addr_in;
         xfer_incr_ff <= xfer_incr_in;
         xfer_left_ff <= xfer_left_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rv_ff <= rv_in;
      resp_ff <= resp_in;
      dv_ff <= dv_in;
      dout_ff <= dout_in;
      irq_ff <= irq_in;
   end

   assign rsp_valid = strobe_ff;
   assign rsp_resp_valid = rv_ff;
   assign rsp_response = resp_ff;
   assign rsp_data_valid = dv_ff;
   assign rsp_data_out = dout_ff;
   assign rsp_card_irq = irq_ff;

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == sdwrd_pkg::ST_EXEC))
      else $error("result strobe without execution cycle");

   a_busy_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == sdwrd_pkg::ST_CLEAR |-> busy && !rsp_valid)
      else $error("request window open during ram clear");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_resp_valid && rsp_data_valid))
      else $error("response and read byte in one result");

   a_quiet_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_resp_valid |-> rsp_response == 32'h0)
      else $error("response word without response");

endmodule
